@@ design/trcf_pkg.sv @@
// ----------------------------------------------------------------------------
// trcf_pkg
// Shared types and constants for the tuple row cut filter.
// ----------------------------------------------------------------------------
`default_nettype none

package trcf_pkg;

  localparam int NUM_CUTS    = 4;
  localparam int MAX_COLUMNS = 256;
  localparam int CUT_REGS    = 4;

  localparam int COL_W     = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SAMPLE_W  = 32;
  localparam int CUT_W     = 44;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT0  = 3'd1;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;

  typedef struct packed {
    logic                       enable;
    logic [7:0]                 column;
    logic [2:0]                 code;
    logic signed [SAMPLE_W-1:0] threshold;
  } cut_t;

  localparam logic [CUT_W-1:0] CUT_RESET = 44'h0_0500000000;

endpackage

`default_nettype wire

@@ design/tuple_row_cut_filter.sv @@
// ----------------------------------------------------------------------------
// tuple_row_cut_filter
// Row selection filter: streams column values, emits one verdict per row.
// ----------------------------------------------------------------------------
// One column value is taken per cycle, back to back, with no gaps between
// rows. Each value is latched in an input register and, in the following
// cycle, compared against all active cuts at once; on the row's last value
// the verdict lands in the output register when the input register advances,
// so a result is offered once the last value has passed the input register
// and then the output register. The input side stalls only when a verdict
// is pending and the output register still holds an untaken one.
// Configuration writes are taken every cycle and are meant for idle time.
`default_nettype none

module tuple_row_cut_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [trcf_pkg::SAMPLE_W-1:0] in_column_sample,
  input  logic                                 in_row_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_row_accepted,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [trcf_pkg::CUT_W-1:0]           cfg_data
);
  import trcf_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);

  logic [COUNT_W-1:0]           count_r;
  cut_t [CUT_REGS-1:0]          cut_r;
  cut_t [NUM_CUTS-1:0]          cuts;

  logic                         s1_valid_r;
  logic signed [SAMPLE_W-1:0]   s1_sample_r;
  logic                         s1_last_r;
  logic                         s1_adv;

  logic [COL_W-1:0]             col_pos_r;
  logic                         pass_r;
  logic                         pass_nxt;
  logic                         any_fail;

  logic                         out_valid_r;
  logic                         out_accepted_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int j = 0; j < CUT_REGS; j++) begin
        cut_r[j] <= cut_t'(CUT_RESET);
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end
      for (int j = 0; j < CUT_REGS; j++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_CUT0) + j)) begin
          cut_r[j] <= cut_t'(cfg_data);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CUTS; i++) begin
      if (i < CUT_REGS) begin
        cuts[i] = cut_r[i];
      end else begin
        cuts[i] = cut_t'(CUT_RESET);
      end
    end
  end

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_column_sample;
      s1_last_r   <= in_row_end;
    end
  end

  trcf_cut_eval u_eval (
    .cuts         (cuts),
    .active_count (count_r),
    .column_pos   (col_pos_r),
    .sample       (s1_sample_r),
    .any_fail     (any_fail)
  );

  assign pass_nxt = pass_r && !any_fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      pass_r    <= 1'b1;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        col_pos_r <= '0;
        pass_r    <= 1'b1;
      end else begin
        pass_r <= pass_nxt;
        if (col_pos_r != COL_LAST) begin
          col_pos_r <= col_pos_r + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_accepted_r <= pass_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_accepted = out_accepted_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_pos_r <= COL_LAST)
    else $error("column position beyond last column");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (col_pos_r == '0) && pass_r)
    else $error("row state not restored after row end");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result without a row end transfer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_adv && s1_last_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ design/trcf_cut_eval.sv @@
// ----------------------------------------------------------------------------
// trcf_cut_eval
// Tests one sample against the active cuts on its column in parallel; flags any failure.
// ----------------------------------------------------------------------------
`default_nettype none

module trcf_cut_eval (
  input  trcf_pkg::cut_t [trcf_pkg::NUM_CUTS-1:0] cuts,
  input  logic [trcf_pkg::COUNT_W-1:0]             active_count,
  input  logic [trcf_pkg::COL_W-1:0]               column_pos,
  input  logic signed [trcf_pkg::SAMPLE_W-1:0]     sample,
  output logic                                     any_fail
);
  import trcf_pkg::*;

  localparam logic [COUNT_W-1:0] NUM_CUTS_C = COUNT_W'(NUM_CUTS);

  logic [COUNT_W-1:0] count_eff;

  function automatic logic cut_pass(input logic [2:0] code,
                                    input logic signed [SAMPLE_W-1:0] a,
                                    input logic signed [SAMPLE_W-1:0] b);
    logic res;
    case (code)
      CMP_EQ:  res = (a == b);
      CMP_NE:  res = (a != b);
      CMP_LT:  res = (a < b);
      CMP_LE:  res = (a <= b);
      CMP_GT:  res = (a > b);
      CMP_GE:  res = (a >= b);
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  assign count_eff = (active_count > NUM_CUTS_C) ? NUM_CUTS_C : active_count;

  always_comb begin
    any_fail = 1'b0;
    for (int i = 0; i < NUM_CUTS; i++) begin
      if ((COUNT_W'(i) < count_eff) && cuts[i].enable &&
          ({1'b0, cuts[i].column} == 9'(column_pos))) begin
        if (!cut_pass(cuts[i].code, sample, cuts[i].threshold)) begin
          any_fail = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
